@@ sv/f4nm_pkg.sv @@
// Shared types and constants for the f4 numerator mean block.
package f4nm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int FREQ_W    = FRAC_BITS + 1;
  localparam int DIFF_W    = FREQ_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int SUM_W     = 51;
  localparam int CNT_W     = 17;
  localparam int MEAN_W    = 18;
  localparam int MAX_SNPS  = 65536;

  // Dividend of the row mean is |sum| >> FRAC_BITS; |sum| stays below 2^49.
  localparam int NUM_W     = 33;
  localparam int STEP_W    = 6;

  localparam int QDEPTH    = 4;
  localparam int QPTR_W    = 2;
  localparam int QCNT_W    = 3;

  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 17;

  localparam logic [FREQ_W-1:0] ONE_Q = FREQ_W'(1) << FRAC_BITS;
  localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_SNPS);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALL_SNPS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_LOW  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_POLY_HIGH = 2'd3;

  // Polymorphism filter modes
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_KEEP_IN = 2'd2;

  typedef struct packed {
    logic signed [DIFF_W-1:0] diff_ab;
    logic signed [DIFF_W-1:0] diff_cd;
    logic                     take;
    logic                     last;
  } q_entry_t;

  typedef struct packed {
    logic                    start;
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
  } div_req_t;

endpackage

@@ sv/f4nm_if.sv @@
// Item channels: SNP input and row result output.
interface f4nm_in_if;
  logic                           valid;
  logic                           ready;
  logic [f4nm_pkg::FREQ_W-1:0]    freq_a;
  logic [f4nm_pkg::FREQ_W-1:0]    freq_b;
  logic [f4nm_pkg::FREQ_W-1:0]    freq_c;
  logic [f4nm_pkg::FREQ_W-1:0]    freq_d;
  logic [3:0]                     missing_mask;
  logic                           snp_used;
  logic                           row_last;

  modport source (output valid, freq_a, freq_b, freq_c, freq_d, missing_mask,
                  snp_used, row_last, input ready);
  modport sink (input valid, freq_a, freq_b, freq_c, freq_d, missing_mask,
                snp_used, row_last, output ready);
endinterface

interface f4nm_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [f4nm_pkg::MEAN_W-1:0] mean_value;
  logic [f4nm_pkg::CNT_W-1:0]         snp_count;
  logic                               mean_defined;

  modport source (output valid, mean_value, snp_count, mean_defined, input ready);
  modport sink (input valid, mean_value, snp_count, mean_defined, output ready);
endinterface

@@ sv/f4_numerator_mean.sv @@
// A row-closing item passes the queue and the product stage; its result is valid once
// the 33-step divider has run, and an empty row skips the divide; the divider starts once per row end.
// Throughput: one SNP per cycle while the queue is not full; the divider takes a new row
// close only while idle, so a row-closing item that comes while it is busy waits.
// A four-entry queue lets input be taken while the accumulator or output stalls.
// Reset (synchronous, active high) clears queue, accumulator, count and divider.
module f4_numerator_mean (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [f4nm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [f4nm_pkg::CFG_W-1:0]     cfg_data,
  f4nm_in_if.sink                        in_item,
  f4nm_out_if.source                     out_item
);
  import f4nm_pkg::*;

  logic     q_full;
  logic     push;
  q_entry_t push_data;
  logic     pop;
  logic     q_valid;
  q_entry_t pop_data;
  logic     div_idle;
  div_req_t div_req;

  f4nm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  f4nm_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .pop_data  (pop_data)
  );

  f4nm_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_data   (pop_data),
    .pop      (pop),
    .div_idle (div_idle),
    .div_req  (div_req)
  );

  f4nm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .div_req  (div_req),
    .div_idle (div_idle),
    .out_item (out_item)
  );

endmodule

@@ sv/f4nm_front.sv @@
// Front end: configuration registers, input accept and SNP classification.
module f4nm_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [f4nm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [f4nm_pkg::CFG_W-1:0]        cfg_data,
  f4nm_in_if.sink                           in_item,
  input  logic                              q_full,
  output logic                              push,
  output f4nm_pkg::q_entry_t                push_data
);
  import f4nm_pkg::*;

  logic [1:0]        poly_mode;
  logic              all_snps;
  logic [FREQ_W-1:0] poly_low;
  logic [FREQ_W-1:0] poly_high;

  logic [FREQ_W-1:0] sat_a, sat_b, sat_c, sat_d;
  logic              all_equal;
  logic              in_bounds;
  logic              poly_drop;
  logic              take;

  always_ff @(posedge clk) begin
    if (rst) begin
      poly_mode <= MODE_OFF;
      all_snps  <= 1'b1;
      poly_low  <= FREQ_W'(7);
      poly_high <= FREQ_W'(65529);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_POLY_MODE: poly_mode <= cfg_data[1:0];
        CFG_ALL_SNPS:  all_snps  <= cfg_data[0];
        CFG_POLY_LOW:  poly_low  <= cfg_data[FREQ_W-1:0];
        CFG_POLY_HIGH: poly_high <= cfg_data[FREQ_W-1:0];
        default: ;
      endcase
    end
  end

  function automatic logic [FREQ_W-1:0] sat(input logic [FREQ_W-1:0] v);
    return (v > ONE_Q) ? ONE_Q : v;
  endfunction

  always_comb begin
    sat_a     = sat(in_item.freq_a);
    sat_b     = sat(in_item.freq_b);
    sat_c     = sat(in_item.freq_c);
    sat_d     = sat(in_item.freq_d);
    all_equal = (sat_a == sat_b) && (sat_a == sat_c) && (sat_a == sat_d);
    in_bounds = (sat_a >= poly_low) && (sat_a <= poly_high);
    // with all_snps set and the mode not off, monomorphic SNPs drop unless mode 2 keeps them inside the bounds
    poly_drop = all_snps && (poly_mode != MODE_OFF) && all_equal &&
                !((poly_mode == MODE_KEEP_IN) && in_bounds);
    take      = (all_snps || in_item.snp_used) && (in_item.missing_mask == 4'd0) &&
                !poly_drop;
  end

  assign in_item.ready = !q_full;
  assign push          = in_item.valid && !q_full;

  assign push_data.diff_ab = $signed({1'b0, sat_a}) - $signed({1'b0, sat_b});
  assign push_data.diff_cd = $signed({1'b0, sat_c}) - $signed({1'b0, sat_d});
  assign push_data.take    = take;
  assign push_data.last    = in_item.row_last;

endmodule

@@ sv/f4nm_fifo.sv @@
// Short queue between the classifier and the accumulate path.
module f4nm_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  f4nm_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output f4nm_pkg::q_entry_t pop_data
);
  import f4nm_pkg::*;

  q_entry_t          entries [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  assign full     = (fill == QCNT_W'(QDEPTH));
  assign q_valid  = (fill != '0);
  assign pop_data = entries[rptr];

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push) else $error("queue written while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid) else $error("queue read while empty");
`endif

endmodule

@@ sv/f4nm_back.sv @@
// Back end: product stage and row accumulator.
module f4nm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  f4nm_pkg::q_entry_t q_data,
  output logic               pop,
  input  logic               div_idle,
  output f4nm_pkg::div_req_t div_req
);
  import f4nm_pkg::*;

  logic                     s1_valid;
  logic signed [PROD_W-1:0] s1_prod;
  logic                     s1_take;
  logic                     s1_last;
  logic                     s1_fire;
  logic                     s1_open;

  logic signed [SUM_W-1:0]  product_sum;
  logic [CNT_W-1:0]         valid_count;
  logic signed [SUM_W-1:0]  sum_next;
  logic [CNT_W-1:0]         count_next;
  logic                     add_now;

  // a row-closing item waits until the divider is free
  assign s1_fire = s1_valid && (!s1_last || div_idle);
  assign s1_open = !s1_valid || s1_fire;
  assign pop     = q_valid && s1_open;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_open) begin
      s1_valid <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_prod <= q_data.diff_ab * q_data.diff_cd;
      s1_take <= q_data.take;
      s1_last <= q_data.last;
    end
  end

  always_comb begin
    add_now    = s1_take && (valid_count < CNT_MAX);
    sum_next   = product_sum;
    count_next = valid_count;
    if (add_now) begin
      sum_next   = product_sum + {{(SUM_W-PROD_W){s1_prod[PROD_W-1]}}, s1_prod};
      count_next = valid_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      product_sum <= '0;
      valid_count <= '0;
    end else if (s1_fire) begin
      if (s1_last) begin
        product_sum <= '0;
        valid_count <= '0;
      end else begin
        product_sum <= sum_next;
        valid_count <= count_next;
      end
    end
  end

  assign div_req.start = s1_fire && s1_last;
  assign div_req.sum   = sum_next;
  assign div_req.count = count_next;

endmodule

@@ sv/f4nm_div.sv @@
// Row mean divider, one quotient bit per cycle, with the result register.
module f4nm_div (
  input  logic               clk,
  input  logic               rst,
  input  f4nm_pkg::div_req_t div_req,
  output logic               div_idle,
  f4nm_out_if.source         out_item
);
  import f4nm_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ABS  = 2'd1;
  localparam logic [1:0] S_RUN  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

  logic [1:0]              state;
  logic signed [SUM_W-1:0] sum_raw;
  logic [SUM_W-1:0]        sum_mag;
  logic [CNT_W-1:0]        divisor;
  logic                    neg;
  logic [NUM_W-1:0]        num;
  logic [CNT_W-1:0]        rem;
  logic [STEP_W-1:0]       step;
  logic [CNT_W:0]          trial;
  logic                    fits;
  logic [MEAN_W-1:0]       quot;

  assign sum_mag = sum_raw[SUM_W-1] ? SUM_W'(-sum_raw) : SUM_W'(sum_raw);
  assign trial   = {rem, num[NUM_W-1]};
  assign fits    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (div_req.start) state <= (div_req.count == '0) ? S_DONE : S_ABS;
        S_ABS:  state <= S_RUN;
        S_RUN:  if (step == LAST_STEP) state <= S_DONE;
        S_DONE: if (out_item.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (div_req.start) begin
          sum_raw <= div_req.sum;
          divisor <= div_req.count;
          neg     <= 1'b0;
          num     <= '0;
        end
      end
      S_ABS: begin
        // drop the fraction bits first: floor(floor(x / 2^16) / n) = floor(x / (n 2^16))
        neg  <= sum_raw[SUM_W-1];
        num  <= sum_mag[FRAC_BITS +: NUM_W];
        rem  <= '0;
        step <= '0;
      end
      S_RUN: begin
        rem  <= fits ? CNT_W'(trial - {1'b0, divisor}) : trial[CNT_W-1:0];
        num  <= {num[NUM_W-2:0], fits};
        step <= step + 1'b1;
      end
      default: ;
    endcase
  end

  assign quot = {{(MEAN_W-CNT_W){1'b0}}, num[CNT_W-1:0]};

  assign div_idle              = (state == S_IDLE);
  assign out_item.valid        = (state == S_DONE);
  assign out_item.mean_value   = neg ? $signed(-quot) : $signed(quot);
  assign out_item.snp_count    = divisor;
  assign out_item.mean_defined = (divisor != '0);

`ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_req.start |-> state == S_IDLE) else $error("divider started while busy");
  a_run_ends: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && step == LAST_STEP) |=> state == S_DONE)
    else $error("divider did not finish");
  a_empty_row: assert property (@(posedge clk) disable iff (rst)
    (out_item.valid && !out_item.mean_defined) |->
      (out_item.mean_value == '0 && out_item.snp_count == '0))
    else $error("empty row result not zero");
`endif

endmodule
